// ===== rtl/arpc_pkg.sv =====
// arpc_pkg: types, codes and constants for the ARP cache.
// No dependencies.
`timescale 1ns / 1ps
package arpc_pkg;
  localparam int unsigned TableEntriesDef = 8;

  typedef enum logic [1:0] {
    FUNC_LEARN = 2'd0,
    FUNC_ARP   = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_LOOK  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_REFRESH = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_EVICT   = 3'd3,
    ACT_EXPIRE  = 3'd4
  } action_e;

  localparam logic [15:0] OpRequest = 16'd1;
  localparam logic [15:0] OpReply   = 16'd2;

  typedef enum logic [2:0] {
    REG_HOST_IP  = 3'd0,
    REG_MASK     = 3'd1,
    REG_OWN_MAC  = 3'd2,
    REG_AGING    = 3'd3,
    REG_MIN_SIZE = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [31:0] dst_ip;
    logic [15:0] arp_opcode;
    logic [10:0] packet_size;
  } in_item_t;

  typedef struct packed {
    logic        send_reply;
    logic [47:0] reply_dst_mac;
    logic [31:0] reply_dst_ip;
    logic [47:0] reply_src_mac;
    logic        hit;
    logic [47:0] hit_mac;
    logic [2:0]  table_action;
  } out_item_t;

  typedef struct packed {
    logic [31:0] host_ip;
    logic [31:0] subnet_mask;
    logic [47:0] own_mac;
    logic [15:0] aging_limit;
    logic [10:0] min_arp_size;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item, compute matches
    logic execute;  // commit table change, build result
  } cmd_t;
endpackage

// ===== rtl/arpc_ctrl.sv =====
// arpc_ctrl: controller FSM sequencing capture, execute and result handoff.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
module arpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output arpc_pkg::cmd_t cmd_o
);
  import arpc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  // Next item is taken as the result is taken.
  assign in_stall_o  = !(state_q == ST_IDLE || (state_q == ST_OUT && !out_stall_i));
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign cmd_o.load    = acc;
  assign cmd_o.execute = (state_q == ST_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall_i) state_d = acc ? ST_EXEC : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end
endmodule

// ===== rtl/arpc_datapath.sv =====
// arpc_datapath: cache table, tick counter, match/age logic, result register.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
module arpc_datapath #(
  parameter int unsigned TableEntries = arpc_pkg::TableEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arpc_pkg::cmd_t      cmd_i,
  input  arpc_pkg::in_item_t  item_i,
  input  arpc_pkg::cfg_t      cfg_i,
  output arpc_pkg::out_item_t result_o
);
  import arpc_pkg::*;

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  logic [31:0] ent_ip_q [TableEntries];
  logic [47:0] ent_mac_q [TableEntries];
  logic [15:0] ent_stamp_q [TableEntries];
  logic [15:0] now_q;
  in_item_t    item_q;
  out_item_t   res_q, res_d;

  // stage 1 registers: per-entry compare flags
  logic [TableEntries-1:0] match_q, free_q, age_q;
  logic [15:0]             age_val_q [TableEntries];

  logic [31:0] key;
  always_comb key = (item_i.func == FUNC_LOOK) ? item_i.dst_ip : item_i.src_ip;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
      for (int k = 0; k < TableEntries; k++) begin
        match_q[k]    <= (ent_ip_q[k] == key);
        free_q[k]     <= (ent_ip_q[k] == 32'd0);
        age_val_q[k]  <= now_q - ent_stamp_q[k];
        // age after the tick increment
        age_q[k]      <= (ent_ip_q[k] != 32'd0) &&
                         (16'(now_q + 16'd1 - ent_stamp_q[k]) >= cfg_i.aging_limit);
      end
    end
  end

  // stage 2 selection
  logic              any_match, any_free, do_upd, on_link, arp_ok;
  logic [IdxW-1:0]   match_idx, free_idx, old_idx, slot;
  logic [15:0]       best;
  logic [47:0]       hmac;

  always_comb begin
    any_match = 1'b0; any_free = 1'b0;
    match_idx = '0; free_idx = '0; old_idx = '0; best = '0; hmac = '0;
    for (int k = TableEntries - 1; k >= 0; k--) begin
      if (match_q[k]) begin any_match = 1'b1; match_idx = IdxW'(k); end
      if (free_q[k])  begin any_free  = 1'b1; free_idx  = IdxW'(k); end
    end
    for (int k = 0; k < TableEntries; k++) begin
      if (age_val_q[k] > best) begin best = age_val_q[k]; old_idx = IdxW'(k); end
    end
    hmac = ent_mac_q[match_idx];
  end

  always_comb begin
    on_link = ((item_q.src_ip ^ cfg_i.host_ip) & cfg_i.subnet_mask) == 32'd0;
    arp_ok  = (item_q.packet_size >= cfg_i.min_arp_size) &&
              (item_q.dst_ip == cfg_i.host_ip);
    do_upd  = 1'b0;
    res_d   = '0;
    unique case (func_e'(item_q.func))
      FUNC_LEARN: do_upd = on_link;
      FUNC_ARP: begin
        if (arp_ok && item_q.arp_opcode == OpRequest) begin
          res_d.send_reply    = 1'b1;
          res_d.reply_dst_mac = item_q.src_mac;
          res_d.reply_dst_ip  = item_q.src_ip;
          res_d.reply_src_mac = cfg_i.own_mac;
        end
        do_upd = arp_ok && item_q.arp_opcode == OpReply;
      end
      FUNC_TICK: if (|age_q) res_d.table_action = ACT_EXPIRE;
      FUNC_LOOK: begin
        if (item_q.dst_ip != 32'd0 && any_match) begin
          res_d.hit = 1'b1;
          res_d.hit_mac = hmac;
        end
      end
      default: ;
    endcase
    if (item_q.src_ip == 32'd0) do_upd = 1'b0;
    slot = any_match ? match_idx : (any_free ? free_idx : old_idx);
    if (do_upd)
      res_d.table_action = any_match ? ACT_REFRESH : (any_free ? ACT_INSERT : ACT_EVICT);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_q <= res_d;
      if (do_upd) begin
        ent_mac_q[slot]   <= item_q.src_mac;
        ent_stamp_q[slot] <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
      for (int k = 0; k < TableEntries; k++) ent_ip_q[k] <= '0;
    end else if (cmd_i.execute) begin
      if (item_q.func == FUNC_TICK) begin
        now_q <= now_q + 16'd1;
        for (int k = 0; k < TableEntries; k++)
          if (age_q[k]) ent_ip_q[k] <= '0;
      end else if (do_upd) begin
        ent_ip_q[slot] <= item_q.src_ip;
      end
    end
  end

  assign result_o = res_q;
endmodule

// ===== rtl/arpc_regs.sv =====
// arpc_regs: APB configuration register file.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
module arpc_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready,
  output arpc_pkg::cfg_t cfg_o
);
  import arpc_pkg::*;

  cfg_t cfg_q;
  logic wr;
  reg_e idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.host_ip      <= 32'd0;
      cfg_q.subnet_mask  <= 32'hFFFF_FF00;
      cfg_q.own_mac      <= 48'd0;
      cfg_q.aging_limit  <= 16'd60;
      cfg_q.min_arp_size <= 11'd28;
    end else if (wr) begin
      unique case (idx)
        REG_HOST_IP:  cfg_q.host_ip      <= pwdata[31:0];
        REG_MASK:     cfg_q.subnet_mask  <= pwdata[31:0];
        REG_OWN_MAC:  cfg_q.own_mac      <= pwdata[47:0];
        REG_AGING:    cfg_q.aging_limit  <= pwdata[15:0];
        REG_MIN_SIZE: cfg_q.min_arp_size <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HOST_IP:  prdata = {32'd0, cfg_q.host_ip};
      REG_MASK:     prdata = {32'd0, cfg_q.subnet_mask};
      REG_OWN_MAC:  prdata = {16'd0, cfg_q.own_mac};
      REG_AGING:    prdata = {48'd0, cfg_q.aging_limit};
      REG_MIN_SIZE: prdata = {53'd0, cfg_q.min_arp_size};
      default:      prdata = 64'd0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

// ===== rtl/arp_cache_with_aging_unit.sv =====
// ARP cache with aging: IP-to-MAC table, TableEntries entries.
// Flow: an accepted item is captured, then executed, before its result is offered.
// Occupancy: one transaction in flight; the next is accepted as its result is taken,
//   since the compare-then-commit pair through the table's flip-flops must finish first.
// Reset: asynchronous active low; all entries free, tick counter zero,
//   registers at their documented defaults. No clearing pass.
`timescale 1ns / 1ps
module arp_cache_with_aging_unit #(
  parameter int unsigned TableEntries = arpc_pkg::TableEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input transaction channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  arpc_pkg::in_item_t  in_item_i,
  // result transaction channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output arpc_pkg::out_item_t out_item_o,
  // configuration (64-bit data, 8-byte register pitch)
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import arpc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  arpc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // Controller: one item in flight; next accepted as result leaves.
  arpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd)
  );

  // Datapath: per-entry compares registered, then update/tick commit.
  arpc_datapath #(.TableEntries(TableEntries)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_item_i), .cfg_i(cfg),
    .result_o(out_item_o)
  );
endmodule

// ===== rtl/arpc_checker.sv =====
// arpc_checker: port-level assertions for the ARP cache, bound to the top.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
module arpc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input arpc_pkg::out_item_t out_item_o
);
  import arpc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed under stall");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.send_reply && out_item_o.hit))
    else $error("reply and hit together");

  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.table_action <= ACT_EXPIRE)
    else $error("bad action code");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted two items back to back");
endmodule

bind arp_cache_with_aging_unit arpc_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_item_o
);

// ===== tb/arp_cache_checker.sv =====
// arp_cache_checker: watches the transaction channels of the ARP cache, predicts
// each result from its own copy of the table and registers, and counts mismatches.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
module arp_cache_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  arpc_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  arpc_pkg::out_item_t out_item_i,
  input  logic                cfg_we_i,
  input  arpc_pkg::reg_e      cfg_idx_i,
  input  logic [63:0]         cfg_val_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  hits_o,
  output int                  replies_o
);
  import arpc_pkg::*;
  localparam int Entries = TableEntriesDef;

  cfg_t        cfg;
  logic [31:0] tbl_ip[Entries];
  logic [47:0] tbl_mac[Entries];
  logic [15:0] tbl_stamp[Entries];
  logic [15:0] ticks;
  out_item_t   expected_q[$];

  assign pending_o = expected_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors_o++;
  endtask

  function automatic action_e table_write(input logic [31:0] ip, input logic [47:0] mac);
    int slot;
    logic [15:0] best, age;
    action_e act;
    slot = -1;
    if (ip == '0) return ACT_NONE;
    for (int k = 0; k < Entries; k++)
      if (tbl_ip[k] == ip) begin
        tbl_mac[k] = mac;
        tbl_stamp[k] = ticks;
        return ACT_REFRESH;
      end
    for (int k = 0; k < Entries; k++)
      if (slot < 0 && tbl_ip[k] == '0) slot = k;
    if (slot >= 0) begin
      act = ACT_INSERT;
    end else begin
      best = '0;
      slot = 0;
      for (int k = 0; k < Entries; k++) begin
        age = ticks - tbl_stamp[k];
        if (age > best) begin
          best = age;
          slot = k;
        end
      end
      act = ACT_EVICT;
    end
    tbl_ip[slot] = ip;
    tbl_mac[slot] = mac;
    tbl_stamp[slot] = ticks;
    return act;
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    logic [15:0] age;
    r = '0;
    r.table_action = ACT_NONE;
    case (func_e'(it.func))
      FUNC_LEARN: begin
        if ((it.src_ip & cfg.subnet_mask) == (cfg.host_ip & cfg.subnet_mask))
          r.table_action = table_write(it.src_ip, it.src_mac);
      end
      FUNC_ARP: begin
        if (it.packet_size >= cfg.min_arp_size && it.dst_ip == cfg.host_ip) begin
          if (it.arp_opcode == OpRequest) begin
            r.send_reply = 1'b1;
            r.reply_dst_mac = it.src_mac;
            r.reply_dst_ip = it.src_ip;
            r.reply_src_mac = cfg.own_mac;
          end else if (it.arp_opcode == OpReply) begin
            r.table_action = table_write(it.src_ip, it.src_mac);
          end
        end
      end
      FUNC_TICK: begin
        ticks = ticks + 16'd1;
        for (int k = 0; k < Entries; k++) begin
          age = ticks - tbl_stamp[k];
          if (tbl_ip[k] != '0 && age >= cfg.aging_limit) begin
            tbl_ip[k] = '0;
            r.table_action = ACT_EXPIRE;
          end
        end
      end
      default: begin
        if (it.dst_ip != '0)
          for (int k = Entries - 1; k >= 0; k--)
            if (tbl_ip[k] == it.dst_ip) begin
              r.hit = 1'b1;
              r.hit_mac = tbl_mac[k];
            end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want, got;
    if (!rst_ni) begin
      cfg = '{host_ip: 32'd0, subnet_mask: 32'hFFFF_FF00, own_mac: 48'd0,
              aging_limit: 16'd60, min_arp_size: 11'd28};
      for (int k = 0; k < Entries; k++) begin
        tbl_ip[k] = '0;
        tbl_mac[k] = '0;
        tbl_stamp[k] = '0;
      end
      ticks = '0;
      expected_q.delete();
      errors_o = 0;
      hits_o = 0;
      replies_o = 0;
    end else begin
      if (cfg_we_i)
        case (cfg_idx_i)
          REG_HOST_IP:  cfg.host_ip = cfg_val_i[31:0];
          REG_MASK:     cfg.subnet_mask = cfg_val_i[31:0];
          REG_OWN_MAC:  cfg.own_mac = cfg_val_i[47:0];
          REG_AGING:    cfg.aging_limit = cfg_val_i[15:0];
          REG_MIN_SIZE: cfg.min_arp_size = cfg_val_i[10:0];
          default: ;
        endcase
      if (out_valid_i && !out_stall_i) begin
        got = out_item_i;
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'(got.table_action), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.send_reply !== want.send_reply)
            report("send_reply", 64'(got.send_reply), 64'(want.send_reply));
          if (got.reply_dst_mac !== want.reply_dst_mac)
            report("reply_dst_mac", 64'(got.reply_dst_mac), 64'(want.reply_dst_mac));
          if (got.reply_dst_ip !== want.reply_dst_ip)
            report("reply_dst_ip", 64'(got.reply_dst_ip), 64'(want.reply_dst_ip));
          if (got.reply_src_mac !== want.reply_src_mac)
            report("reply_src_mac", 64'(got.reply_src_mac), 64'(want.reply_src_mac));
          if (got.hit !== want.hit)
            report("hit", 64'(got.hit), 64'(want.hit));
          if (got.hit_mac !== want.hit_mac)
            report("hit_mac", 64'(got.hit_mac), 64'(want.hit_mac));
          if (got.table_action !== want.table_action)
            report("table_action", 64'(got.table_action), 64'(want.table_action));
          hits_o += want.hit;
          replies_o += want.send_reply;
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_result(in_item_i));
    end
  end
endmodule

// ===== tb/arp_cache_with_aging_unit_tb.sv =====
// arp_cache_with_aging_unit_tb: stimulus and verdict for the ARP cache.
// Depends on arpc_pkg, arp_cache_with_aging_unit and arp_cache_checker.
`timescale 1ns / 1ps
module arp_cache_with_aging_unit_tb;
  import arpc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int errors, pending, hits, replies;
  int send_idle_pct, recv_stall_pct;   // idle / stall odds per cycle, percent

  // Current register values, mirrored here so stimulus can aim at our subnet.
  logic [31:0] host_ip = 32'd0;
  logic [31:0] net_mask = 32'hFFFF_FF00;
  logic [10:0] min_size = 11'd28;
  logic [31:0] known_ip[8];            // small pool so refresh/evict/hit happen often

  // A config write lands at the edge where psel, penable, pwrite and pready are high.
  wire cfg_we = psel && penable && pwrite && pready;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  arp_cache_with_aging_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  arp_cache_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(reg_e'(paddr[5:3])), .cfg_val_i(pwdata),
    .errors_o(errors), .pending_o(pending), .hits_o(hits), .replies_o(replies)
  );

  // Receiver: random stall per cycle; the stall odds follow the current phase.
  always @(posedge clk_i) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Hard limit, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

  task automatic reg_write(input reg_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_HOST_IP:  host_ip = val[31:0];
      REG_MASK:     net_mask = val[31:0];
      REG_MIN_SIZE: min_size = val[10:0];
      default: ;
    endcase
  endtask

  // Send one transaction: optional idle cycles first, then hold until accepted.
  // valid drops at the accepting edge; the next send raises it again.
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk_i);
      in_valid <= 1'b0;
    end
    @(posedge clk_i);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (in_stall);
    in_valid <= 1'b0;
  endtask

  // Wait until every expected result is back, plus the pipeline latency.
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [31:0] local_ip();
    logic [31:0] ip;
    ip = (host_ip & net_mask) | ($urandom() & ~net_mask);
    return ip;
  endfunction

  function automatic in_item_t make_item(input func_e f, input logic [31:0] sip,
                                         input logic [31:0] dip, input logic [15:0] op,
                                         input logic [10:0] sz);
    in_item_t it;
    it.func = f;
    it.src_ip = sip;
    it.src_mac = 48'({$urandom(), $urandom()});
    it.dst_ip = dip;
    it.arp_opcode = op;
    it.packet_size = sz;
    return it;
  endfunction

  // Mostly well-formed traffic from a small local pool, some noise.
  function automatic in_item_t random_item();
    in_item_t it;
    logic [31:0] ip;
    int pick;
    pick = $urandom_range(99);
    ip = ($urandom_range(3) == 0) ? local_ip() : known_ip[3'($urandom_range(7))];
    if (pick < 30)
      it = make_item(FUNC_LEARN, ip, $urandom(), 16'($urandom()), 11'($urandom()));
    else if (pick < 55)
      it = make_item(FUNC_ARP, ip, ($urandom_range(7) == 0) ? $urandom() : host_ip,
                     ($urandom_range(7) == 0) ? 16'($urandom()) :
                     16'($urandom_range(1, 2)),
                     ($urandom_range(7) == 0) ? 11'($urandom()) :
                     11'($urandom_range(min_size, 2047)));
    else if (pick < 75)
      it = make_item(FUNC_TICK, $urandom(), $urandom(), 16'($urandom()),
                     11'($urandom()));
    else if (pick < 95)
      it = make_item(FUNC_LOOK, $urandom(), known_ip[3'($urandom_range(7))],
                     16'($urandom()), 11'($urandom()));
    else
      it = make_item(func_e'($urandom_range(3)), $urandom(), $urandom(),
                     16'($urandom()), 11'($urandom()));
    if ($urandom_range(3) == 0) it.src_ip = ~it.src_ip & 32'hFFFF_FFFF;
    return it;
  endfunction

  initial begin
    in_item_t it;
    int items;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < 8; k++) known_ip[k] = 32'h0A00_0001 + k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every function, field extremes and the special cases.
    reg_write(REG_HOST_IP, 64'h0A00_0000);
    reg_write(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF);
    reg_write(REG_AGING, 64'd3);
    host_ip = 32'h0A00_0000;
    send(make_item(FUNC_LEARN, 32'h0A00_0001, 0, 0, 0));            // insert
    send(make_item(FUNC_LEARN, 32'h0A00_0001, 0, 0, 0));            // refresh
    send(make_item(FUNC_LEARN, 32'hC0A8_0101, 0, 0, 0));            // off subnet
    send(make_item(FUNC_LEARN, 32'h0000_0000, 0, 0, 0));            // zero address
    send(make_item(FUNC_ARP, 32'h0A00_0077, host_ip, OpRequest, 28));   // reply asked
    send(make_item(FUNC_ARP, 32'h0A00_0077, host_ip, OpRequest, 27));   // too short
    send(make_item(FUNC_ARP, 32'hFFFF_FFFF, host_ip, OpReply, 11'h7FF));// reply for us
    send(make_item(FUNC_ARP, 32'h0A00_0078, 32'h1, OpReply, 100));   // not for us
    send(make_item(FUNC_ARP, 32'h0A00_0079, host_ip, 16'hFFFF, 100)); // other opcode
    send(make_item(FUNC_LOOK, 0, 32'h0A00_0001, 0, 0));              // hit
    send(make_item(FUNC_LOOK, 0, 32'h0000_0000, 0, 0));              // zero: miss
    send(make_item(FUNC_LOOK, 0, 32'hFFFF_FFFF, 0, 0));
    for (int k = 2; k < 12; k++)                                     // fill then evict
      send(make_item(FUNC_LEARN, 32'h0A00_0000 + k, 0, 0, 0));
    repeat (3) send(make_item(FUNC_TICK, 0, 0, 0, 0));               // expire
    drain();
    reg_write(REG_AGING, 64'd0);                                     // expire on every tick
    reg_write(REG_MIN_SIZE, 64'd0);
    send(make_item(FUNC_LEARN, 32'h0A00_0005, 0, 0, 0));
    send(make_item(FUNC_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 11'h7FF));
    drain();

    // Random phases with rotating register settings, extremes included.
    items = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      drain();
      reg_write(REG_HOST_IP, (ph == 7) ? 64'hFFFF_FFFF : 64'h0A00_0000 | $urandom_range(255));
      reg_write(REG_MASK, (ph == 5) ? 64'd0 : (ph == 6) ? 64'hFFFF_FFFF : 64'hFFFF_FF00);
      reg_write(REG_OWN_MAC, {$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF);
      reg_write(REG_AGING, (ph == 3) ? 64'd65535 : (ph == 4) ? 64'd1 : $urandom_range(2, 40));
      reg_write(REG_MIN_SIZE, (ph == 2) ? 64'd2047 : $urandom_range(0, 64));
      for (int k = 0; k < 8; k++) known_ip[k] = local_ip() | 32'd1;
      for (int n = 0; n < 232; n++) begin
        it = random_item();
        send(it);
        items++;
        if (n == 100) begin
          // sender holds off until everything in flight has come back
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
    end
    recv_stall_pct = 0;
    drain();

    $display("covered %0d random transactions in 8 phases plus directed cases", items);
    $display("lookup hits %0d, ARP replies requested %0d", hits, replies);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
